// ===== src/mcoc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcoc_pkg
// Shared types and codes for the matrix chain order cost block.
// ----------------------------------------------------------------------------
package mcoc_pkg;

  localparam int DimValueW = 12;
  localparam int MinCostW  = 40;
  localparam int TopSplitW = 4;
  localparam int StatusW   = 2;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_FEW  = 2'd1;
  localparam logic [StatusW-1:0] ST_MANY = 2'd2;

  typedef struct packed {
    logic [DimValueW-1:0] dim_value;
    logic                 last_dim;
  } dim_item_t;

  typedef struct packed {
    logic [MinCostW-1:0]  min_cost;
    logic [TopSplitW-1:0] top_split;
    logic [StatusW-1:0]   status;
  } res_item_t;

  // controller to datapath
  typedef struct packed {
    logic store;   // take one dimension item
    logic rd_dj;   // read dims[j], start a new interval
    logic rd_de;   // read dims[e+1], latch dims[j]
    logic lat_de;  // latch dims[e+1]
    logic rd_k;    // read sub-costs and dims[k+1]
    logic mul1;    // first product and sub-cost sum
    logic mul2;    // second product
    logic acc;     // compare and keep best split
    logic wr;      // write interval cost, advance interval
    logic emit;    // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic direct;    // chain closes without a table fill
    logic k_last;    // current split is the last of the interval
    logic iv_end;    // interval is the last of its length
    logic fill_end;  // length is the full chain
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

// ===== src/mcoc_datapath.sv =====
// ----------------------------------------------------------------------------
// mcoc_datapath
// Dimension store, interval cost memory, split search arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module mcoc_datapath #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  mcoc_pkg::dim_item_t dim_item,
  input  mcoc_pkg::cmd_t     cmd,
  output mcoc_pkg::sts_t     sts,
  output logic               res_valid,
  input  logic               res_ready,
  output mcoc_pkg::res_item_t res_item
);

  localparam int MaxDims = MAX_MATRICES + 1;
  localparam int IW      = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int AW      = $clog2(MaxDims);
  localparam int CW      = $clog2(MaxDims + 1);
  localparam int CostW   = 3 * DIM_BITS + IW;
  localparam int CostDep = 1 << (2 * IW);

  logic [DIM_BITS-1:0] dims [0:MaxDims-1];
  logic [CostW-1:0]    cost_mem [0:CostDep-1];

  logic [CW-1:0]       count;
  logic                ovf;
  logic [IW-1:0]       mlast, len, j, k;
  logic [IW-1:0]       e, kp1;
  logic [AW-1:0]       dims_addr;
  logic [DIM_BITS-1:0] dims_q, dj, de;
  logic [CostW-1:0]    c1_q, c2_q, sum, best, tot;
  logic                d1, d2;
  logic [2*DIM_BITS-1:0] p1;
  logic [3*DIM_BITS-1:0] p;
  logic [IW-1:0]       bsplit;
  logic                full, ovf_new;
  logic [CW-1:0]       cnt_new;
  logic [mcoc_pkg::StatusW-1:0] code;
  logic [CostW-1:0]    r_cost;
  logic [IW-1:0]       r_split;
  logic [mcoc_pkg::StatusW-1:0] r_code;

  assign e   = j + len;
  assign kp1 = k + 1'b1;
  assign tot = sum + CostW'(p);

  assign full    = (count == CW'(MaxDims));
  assign ovf_new = ovf | full;
  assign cnt_new = full ? count : count + 1'b1;

  always_comb begin
    if (ovf_new) begin
      code = mcoc_pkg::ST_MANY;
    end else if (cnt_new < CW'(2)) begin
      code = mcoc_pkg::ST_FEW;
    end else begin
      code = mcoc_pkg::ST_OK;
    end
  end

  always_comb begin
    if (cmd.rd_dj) begin
      dims_addr = AW'(j);
    end else if (cmd.rd_de) begin
      dims_addr = AW'(e) + 1'b1;
    end else begin
      dims_addr = AW'(kp1);
    end
  end

  assign sts.direct   = ovf_new || (cnt_new < CW'(3));
  assign sts.k_last   = (kp1 == e);
  assign sts.iv_end   = (e == mlast);
  assign sts.fill_end = (len == mlast);
  assign sts.out_free = !res_valid || res_ready;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      dims[count[AW-1:0]] <= DIM_BITS'(dim_item.dim_value);
    end
    dims_q <= dims[dims_addr];
    if (cmd.wr) begin
      cost_mem[{j, e}] <= best;
    end
    c1_q <= cost_mem[{j, k}];
    c2_q <= cost_mem[{kp1, e}];
  end

  // arithmetic and indexes
  always_ff @(posedge clk) begin
    if (cmd.store && dim_item.last_dim) begin
      r_code  <= code;
      r_cost  <= '0;
      r_split <= '0;
      mlast   <= IW'(cnt_new - CW'(2));
      len     <= IW'(1);
      j       <= '0;
    end
    if (cmd.rd_dj) begin
      k <= j;
    end
    if (cmd.rd_de) begin
      dj <= dims_q;
    end
    if (cmd.lat_de) begin
      de <= dims_q;
    end
    if (cmd.rd_k) begin
      d1 <= (k == j);
      d2 <= (kp1 == e);
    end
    if (cmd.mul1) begin
      p1  <= dj * dims_q;
      sum <= (d1 ? '0 : c1_q) + (d2 ? '0 : c2_q);
    end
    if (cmd.mul2) begin
      p <= p1 * de;
    end
    if (cmd.acc) begin
      // strict compare keeps the first split on a tie
      if (k == j || tot < best) begin
        best   <= tot;
        bsplit <= k;
      end
      if (kp1 != e) begin
        k <= kp1;
      end
    end
    if (cmd.wr) begin
      if (e == mlast) begin
        if (len == mlast) begin
          r_cost  <= best;
          r_split <= bsplit;
        end else begin
          len <= len + 1'b1;
          j   <= '0;
        end
      end else begin
        j <= j + 1'b1;
      end
    end
    if (cmd.emit) begin
      res_item.min_cost  <= mcoc_pkg::MinCostW'(r_cost);
      res_item.top_split <= mcoc_pkg::TopSplitW'(r_split);
      res_item.status    <= r_code;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (dim_item.last_dim) begin
          count <= '0;
          ovf   <= 1'b0;
        end else begin
          count <= cnt_new;
          ovf   <= ovf_new;
        end
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/mcoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcoc_ctrl
// Sequencer for load, table fill by chain length and result hand-off.
// ----------------------------------------------------------------------------
module mcoc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                dim_valid,
  input  mcoc_pkg::dim_item_t dim_item,
  output logic                dim_ready,
  input  mcoc_pkg::sts_t      sts,
  output mcoc_pkg::cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_LOAD = 10'b0000000001,
    S_DJ   = 10'b0000000010,
    S_DE   = 10'b0000000100,
    S_DL   = 10'b0000001000,
    S_RD   = 10'b0000010000,
    S_M1   = 10'b0000100000,
    S_M2   = 10'b0001000000,
    S_ACC  = 10'b0010000000,
    S_WR   = 10'b0100000000,
    S_RES  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign dim_ready = (state == S_LOAD);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        cmd.store = dim_valid;
        if (dim_valid && dim_item.last_dim) begin
          state_next = sts.direct ? S_RES : S_DJ;
        end
      end
      S_DJ: begin
        cmd.rd_dj  = 1'b1;
        state_next = S_DE;
      end
      S_DE: begin
        cmd.rd_de  = 1'b1;
        state_next = S_DL;
      end
      S_DL: begin
        cmd.lat_de = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_k   = 1'b1;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.mul1   = 1'b1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul2   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.k_last ? S_WR : S_RD;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (sts.iv_end && sts.fill_end) begin
          state_next = S_RES;
        end else begin
          state_next = S_DJ;
        end
      end
      S_RES: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/matrix_chain_order_cost.sv =====
// ----------------------------------------------------------------------------
// matrix_chain_order_cost
// Minimum scalar multiplication count and outermost split of a matrix chain.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  dim     | dim_valid, dim_ready, dim_item  | in
//  res     | res_valid, res_ready, res_item  | out
//
// A dimension item that does not close the chain leaves the sequencer loading.
// A closing item starts the table fill, paced by the split loop: each split
// steps through a memory read, two multiplies and a compare, and each
// interval adds reads of its dimensions and a cost write.
// Chains without a fill skip the loop. Reset is synchronous, active high.
// A stalled result holds the sequencer; dimension items of the next chain
// are taken once the result sits in the output register.
// ----------------------------------------------------------------------------
module matrix_chain_order_cost #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                dim_valid,
  output logic                dim_ready,
  input  mcoc_pkg::dim_item_t dim_item,
  output logic                res_valid,
  input  logic                res_ready,
  output mcoc_pkg::res_item_t res_item
);

  mcoc_pkg::cmd_t cmd;
  mcoc_pkg::sts_t sts;

  mcoc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .dim_valid (dim_valid),
    .dim_item  (dim_item),
    .dim_ready (dim_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcoc_datapath #(
    .MAX_MATRICES (MAX_MATRICES),
    .DIM_BITS     (DIM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .dim_item  (dim_item),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

// ===== src/mcoc_checker.sv =====
// ----------------------------------------------------------------------------
// mcoc_checker
// Port-level checks for the matrix chain order cost block.
// ----------------------------------------------------------------------------
module mcoc_checker (
  input logic                clk,
  input logic                rst,
  input logic                dim_valid,
  input logic                dim_ready,
  input mcoc_pkg::dim_item_t dim_item,
  input logic                res_valid,
  input logic                res_ready,
  input mcoc_pkg::res_item_t res_item
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result item changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    dim_valid && dim_ready && dim_item.last_dim |=> !dim_ready)
    else $error("item taken right after chain end");

  a_res_from_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !$past(res_valid) |-> !$past(dim_ready))
    else $error("result appeared while loading");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.status == mcoc_pkg::ST_OK
               || res_item.status == mcoc_pkg::ST_FEW
               || res_item.status == mcoc_pkg::ST_MANY)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status != mcoc_pkg::ST_OK
      |-> res_item.min_cost == '0 && res_item.top_split == '0)
    else $error("error result carries a cost");

endmodule

bind matrix_chain_order_cost mcoc_checker u_mcoc_checker (
  .clk       (clk),
  .rst       (rst),
  .dim_valid (dim_valid),
  .dim_ready (dim_ready),
  .dim_item  (dim_item),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives dimension chains into matrix_chain_order_cost and checks each result
// against an interval dynamic-programming predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb;

  localparam int MaxMats = 16;
  localparam int MaxDims = MaxMats + 1;
  localparam int Limit   = 2000000;

  class chain_cost_board;
    logic [mcoc_pkg::DimValueW-1:0] dims[MaxDims];
    int unsigned                    dim_cnt;
    bit                             overflow;
    mcoc_pkg::res_item_t            pending[$];
    int                             err_cnt;

    function new();
      dim_cnt  = 0;
      overflow = 0;
      err_cnt  = 0;
    endfunction

    function mcoc_pkg::res_item_t solve_chain();
      logic [63:0]         cost[MaxMats][MaxMats];
      logic [3:0]          cut[MaxMats][MaxMats];
      logic [63:0]         best, c;
      logic [3:0]          where;
      mcoc_pkg::res_item_t r;
      int unsigned         m;
      r = '0;
      if (overflow) begin
        r.status = mcoc_pkg::ST_MANY;
      end else if (dim_cnt < 2) begin
        r.status = mcoc_pkg::ST_FEW;
      end else begin
        m = dim_cnt - 1;
        for (int j = 0; j < m; j++) begin
          cost[j][j] = '0;
          cut[j][j]  = 4'(j);
        end
        for (int len = 1; len < m; len++) begin
          for (int j = 0; j + len < m; j++) begin
            best  = '1;
            where = 4'(j);
            for (int k = j; k < j + len; k++) begin
              c = cost[j][k] + cost[k+1][j+len]
                + 64'(dims[j]) * 64'(dims[k+1]) * 64'(dims[j+len+1]);
              if (k == j || c < best) begin
                best  = c;
                where = 4'(k);
              end
            end
            cost[j][j+len] = best;
            cut[j][j+len]  = where;
          end
        end
        r.status    = mcoc_pkg::ST_OK;
        r.min_cost  = cost[0][m-1][mcoc_pkg::MinCostW-1:0];
        r.top_split = (m > 1) ? cut[0][m-1] : 4'd0;
      end
      return r;
    endfunction

    function void note_dim(mcoc_pkg::dim_item_t it);
      if (dim_cnt < MaxDims) begin
        dims[dim_cnt] = it.dim_value;
        dim_cnt++;
      end else begin
        overflow = 1;
      end
      if (it.last_dim) begin
        pending.push_back(solve_chain());
        dim_cnt  = 0;
        overflow = 0;
      end
    endfunction

    task check_result(mcoc_pkg::res_item_t got);
      mcoc_pkg::res_item_t exp_r;
      if (pending.size() == 0) begin
        report_miss("result with nothing pending");
        return;
      end
      exp_r = pending.pop_front();
      if (got.min_cost !== exp_r.min_cost)
        report_miss($sformatf("min_cost got %0d want %0d", got.min_cost, exp_r.min_cost));
      if (got.top_split !== exp_r.top_split)
        report_miss($sformatf("top_split got %0d want %0d", got.top_split,
                              exp_r.top_split));
      if (got.status !== exp_r.status)
        report_miss($sformatf("status got %0d want %0d", got.status, exp_r.status));
    endtask

    task report_miss(string msg);
      err_cnt++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask
  endclass

  logic                clk = 0;
  logic                rst = 1;
  logic                dim_valid = 0;
  logic                dim_ready;
  mcoc_pkg::dim_item_t dim_item = '0;
  logic                res_valid;
  logic                res_ready = 0;
  mcoc_pkg::res_item_t res_item;

  chain_cost_board board = new();
  int  cycle_cnt = 0;

  matrix_chain_order_cost i_dut (
    .clk(clk), .rst(rst),
    .dim_valid(dim_valid), .dim_ready(dim_ready), .dim_item(dim_item),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && dim_valid && dim_ready) board.note_dim(dim_item);
    if (!rst && res_valid && res_ready) board.check_result(res_item);
    if (cycle_cnt > Limit) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver: random stalls before each accept
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = $urandom_range(0, 3);
      if (w > 0) begin
        res_ready <= 0;
        repeat (w) @(negedge clk);
      end
      res_ready <= 1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_dim(logic [mcoc_pkg::DimValueW-1:0] v, logic last, bit gaps = 1);
    int w;
    w = gaps ? $urandom_range(0, 3) : 0;
    if (w > 0) begin
      dim_valid <= 0;
      repeat (w) @(negedge clk);
    end
    dim_valid <= 1;
    dim_item  <= '{dim_value: v, last_dim: last};
    @(posedge clk);
    while (!dim_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // n dimensions with value drawn from a range; chain closed on the last
  task automatic send_chain(int n, int lo, int hi, bit gaps = 1);
    for (int i = 0; i < n; i++)
      send_dim(mcoc_pkg::DimValueW'($urandom_range(lo, hi)), i == n - 1, gaps);
  endtask

  task automatic drain();
    dim_valid <= 0;
    do @(negedge clk); while (board.pending.size() != 0);
  endtask

  initial begin
    int n, r;
    repeat (3) @(negedge clk);
    rst <= 0;
    // directed: too few, single, pair, extremes, ties, overflow
    send_dim(12'd7, 1'b1);
    send_dim(12'd0, 1'b0); send_dim(12'd0, 1'b1);
    send_dim(12'hfff, 1'b0); send_dim(12'hfff, 1'b0); send_dim(12'hfff, 1'b1);
    send_chain(17, 4095, 4095);
    send_chain(4, 5, 5);
    send_dim(12'd10, 1'b0); send_dim(12'd100, 1'b0);
    send_dim(12'd5, 1'b0); send_dim(12'd50, 1'b1);
    drain();
    send_chain(19, 0, 4095, 0);
    send_chain(17, 0, 4095, 0);
    send_dim(12'h555, 1'b0); send_dim(12'haaa, 1'b1);
    drain();
    // random: mostly well-formed chains, some short and over-long
    r = 0;
    while (r < 950) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(1, 2);
        1:       n = $urandom_range(18, 20);
        2:       n = 17;
        default: n = $urandom_range(3, 9);
      endcase
      if ($urandom_range(0, 3) == 0) send_chain(n, 0, 4095);
      else if ($urandom_range(0, 1)) send_chain(n, 0, 15);
      else send_chain(n, 4000, 4095);
      r += n;
      if ($urandom_range(0, 29) == 0) drain();
    end
    drain();
    repeat (2000) @(negedge clk);
    if (board.err_cnt == 0 && board.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
